// ----- src/f32tm_pkg.sv -----
// ----------------------------------------------------------------------------
// f32tm_pkg: shared types for the truncating float32 multiplier
// Operand and result word layouts, constants.
// ----------------------------------------------------------------------------
package f32tm_pkg;

    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [9:0]  EXP_BIAS = 10'd127;

    typedef struct packed {
        logic [31:0] a_bits;
        logic [31:0] b_bits;
    } f32tm_in_t;

    typedef struct packed {
        logic [31:0] product_bits;
        logic        exponent_wrapped;
    } f32tm_out_t;

endpackage

// ----- src/float32_truncating_multiplier.sv -----
// ----------------------------------------------------------------------------
// float32_truncating_multiplier: pipelined single-precision multiply
// Truncated mantissa, exponent kept modulo 256, wrap flag.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operands on in_word and pulse start; a word is taken on every edge
//   where start is high and busy is low. busy is tied low: one word can enter
//   every cycle.
//   Each result appears on out_word for one cycle with done high, once its
//   operands were taken and passed the stages (stage 1: decode and special cases,
//   stage 2: 24x12 partial products, stage 3: sum to 48-bit product,
//   stage 4: normalize and pack). Results leave in entry order.
//   The 24x24 mantissa product, split into two 24x12 halves, sets the depth.
//   Throughput is one word per cycle.
//   Reset clears all valid bits; no result appears until a word enters.
//   The receiver cannot stall; results must be taken as they come.
// ----------------------------------------------------------------------------
module float32_truncating_multiplier
    import f32tm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  f32tm_in_t  in_word,
    output logic       busy,
    output logic       done,
    output f32tm_out_t out_word
);

    logic        take;
    logic [3:0]  vld_reg;

    // stage 1
    logic        s1_bypass_reg;
    logic [31:0] s1_bypass_val_reg;
    logic        s1_sign_reg;
    logic [9:0]  s1_exp_reg;
    logic [23:0] s1_ma_reg, s1_mb_reg;
    logic        bypass_next;
    logic [31:0] bypass_val_next;

    // stage 2
    logic        s2_bypass_reg;
    logic [31:0] s2_bypass_val_reg;
    logic        s2_sign_reg;
    logic [9:0]  s2_exp_reg;
    logic [35:0] s2_plo_reg, s2_phi_reg;

    // stage 3
    logic        s3_bypass_reg;
    logic [31:0] s3_bypass_val_reg;
    logic        s3_sign_reg;
    logic [9:0]  s3_exp_reg;
    logic [47:0] s3_prod_reg;

    // stage 4
    f32tm_out_t  out_reg, out_next;
    logic [24:0] top;
    logic [9:0]  exp_adj;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_comb
    begin
        bypass_next     = 1'b1;
        bypass_val_next = 32'd0;
        priority if (in_word.a_bits[30:0] == 31'd0 || in_word.b_bits[30:0] == 31'd0)
        begin
            bypass_val_next = 32'd0;
        end
        else if (in_word.a_bits == ONE_BITS)
        begin
            bypass_val_next = in_word.b_bits;
        end
        else if (in_word.b_bits == ONE_BITS)
        begin
            bypass_val_next = in_word.a_bits;
        end
        else if (in_word.a_bits[30:23] == 8'd0 || in_word.b_bits[30:23] == 8'd0)
        begin
            bypass_val_next = 32'd0;
        end
        else
        begin
            bypass_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 4'd0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bypass_reg     <= bypass_next;
        s1_bypass_val_reg <= bypass_val_next;
        s1_sign_reg       <= in_word.a_bits[31] ^ in_word.b_bits[31];
        s1_exp_reg        <= {2'b00, in_word.a_bits[30:23]}
                           + {2'b00, in_word.b_bits[30:23]} - EXP_BIAS;
        s1_ma_reg         <= {1'b1, in_word.a_bits[22:0]};
        s1_mb_reg         <= {1'b1, in_word.b_bits[22:0]};

        s2_bypass_reg     <= s1_bypass_reg;
        s2_bypass_val_reg <= s1_bypass_val_reg;
        s2_sign_reg       <= s1_sign_reg;
        s2_exp_reg        <= s1_exp_reg;
        s2_plo_reg        <= 36'(s1_ma_reg * s1_mb_reg[11:0]);
        s2_phi_reg        <= 36'(s1_ma_reg * s1_mb_reg[23:12]);

        s3_bypass_reg     <= s2_bypass_reg;
        s3_bypass_val_reg <= s2_bypass_val_reg;
        s3_sign_reg       <= s2_sign_reg;
        s3_exp_reg        <= s2_exp_reg;
        s3_prod_reg       <= {12'd0, s2_plo_reg} + {s2_phi_reg, 12'd0};

        out_reg           <= out_next;
    end

    always_comb
    begin
        top     = s3_prod_reg[47:23];
        exp_adj = s3_exp_reg + {9'd0, top[24]};
        if (top[24])
        begin
            top = {1'b0, top[24:1]};
        end
        if (s3_bypass_reg)
        begin
            out_next.product_bits     = s3_bypass_val_reg;
            out_next.exponent_wrapped = 1'b0;
        end
        else
        begin
            out_next.product_bits     = {s3_sign_reg, exp_adj[7:0], top[22:0]};
            // signed 10-bit exponent outside 1..254
            out_next.exponent_wrapped = exp_adj[9] || exp_adj == 10'd0
                                     || exp_adj > 10'd254;
        end
    end

    assign done     = vld_reg[3];
    assign out_word = out_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##4 done)
        else $error("result missing four cycles after entry");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, 4))
        else $error("result without entry");
    a_bypass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && s3_bypass_reg |=> !out_reg.exponent_wrapped)
        else $error("wrap flag on special case");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the truncating float32 multiplier
// Directed corner operands, then random operand pairs under several idle
// patterns; each result is checked against a behavioral product model.
// ----------------------------------------------------------------------------
module tb_top;
    import f32tm_pkg::*;

    localparam int LATENCY   = 4;
    localparam int MAX_CYCLE = 200000;

    class product_board;
        f32tm_out_t pending[$];
        int         errors;
        int         checked;

        // truncating product with the exponent kept modulo 256
        function f32tm_out_t mul_trunc(logic [31:0] a, logic [31:0] b);
            f32tm_out_t  r;
            logic [7:0]  ea;
            logic [7:0]  eb;
            logic [47:0] prod;
            logic [24:0] top;
            int          e;
            ea = a[30:23];
            eb = b[30:23];
            r  = '0;
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                return r;
            if (a == ONE_BITS)
            begin
                r.product_bits = b;
                return r;
            end
            if (b == ONE_BITS)
            begin
                r.product_bits = a;
                return r;
            end
            if (ea == 8'd0 || eb == 8'd0)
                return r;
            prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
            top  = prod[47:23];
            e    = int'(ea) + int'(eb) - 127;
            if (top[24])
            begin
                top = top >> 1;
                e   = e + 1;
            end
            r.product_bits     = {a[31] ^ b[31], e[7:0], top[22:0]};
            r.exponent_wrapped = (e < 1 || e > 254);
            return r;
        endfunction

        function void note_operands(f32tm_in_t w);
            pending.push_back(mul_trunc(w.a_bits, w.b_bits));
        endfunction

        function void check_product(f32tm_out_t got);
            f32tm_out_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.product_bits !== want.product_bits)
                report_mismatch($sformatf("product %h, want %h",
                                          got.product_bits, want.product_bits));
            if (got.exponent_wrapped !== want.exponent_wrapped)
                report_mismatch($sformatf("wrap flag %b, want %b (product %h)",
                                          got.exponent_wrapped,
                                          want.exponent_wrapped,
                                          want.product_bits));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("MISMATCH: %s", msg);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    f32tm_in_t  in_word;
    logic       busy;
    logic       done;
    f32tm_out_t out_word;

    product_board board;
    int           cycle;
    int           idle_pct;
    int           sent;

    float32_truncating_multiplier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_word  (in_word),
        .busy     (busy),
        .done     (done),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (rst_n && done)
            board.check_product(out_word);
        if (rst_n && start && !busy)
            board.note_operands(in_word);
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // hold start over a random idle gap, then present one word until taken
    task automatic send_word(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        in_word.a_bits  <= a;
        in_word.b_bits  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // operand biased toward normal numbers with a chosen exponent range
    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'($urandom_range(1, 20));
            3: v[30:23] = 8'($urandom_range(235, 254));
            4: v = ONE_BITS;
            5: v[30:0] = 31'd0;
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] corner[12];
        int          phase;
        board   = new();
        cycle   = 0;
        sent    = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        in_word = '0;
        idle_pct = 0;
        corner = '{32'h0000_0000, 32'h8000_0000, ONE_BITS, 32'hBF80_0000,
                   32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF80_0000,
                   32'h7FFF_FFFF, 32'h0080_0000, 32'h3FFF_FFFF, 32'hC000_0000};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner pairs: zeros, ones, denormals, overflow and underflow wrap
        for (int i = 0; i < 12; i += 2)
        begin
            send_word(corner[i], corner[i + 1]);
            send_word(corner[i + 1], corner[(i + 5) % 12]);
        end
        send_word(ONE_BITS, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, ONE_BITS);
        send_word(ONE_BITS, ONE_BITS);
        send_word(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_word(32'h0080_0000, 32'h0080_0000);
        send_word(32'h3FFF_FFFF, 32'h3FFF_FFFF);
        send_word(32'h3F80_0001, 32'h3F80_0001);
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 56 : (phase == 3) ? 30 : 0;
            for (int n = 0; n < 220; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_word($urandom, $urandom);
                else
                    send_word(rand_float(), rand_float());
            end
            drain();
        end

        repeat (LATENCY + 4) @(posedge clk);
        $display("covered %0d operand pairs, %0d products checked", sent,
                 board.checked);
        $display("idle patterns: none, 56%% and 30%% sender gaps, drains between");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- sim.f -----
src/f32tm_pkg.sv
src/float32_truncating_multiplier.sv
test/tb_top.sv
